// ===== src/region_offset_resolver_macros.svh =====
// ----------------------------------------------------------------------------
// Region offset resolver assertion macros
// Shared property forms for the concurrent checks of the resolver.
// ----------------------------------------------------------------------------
`ifndef REGION_OFFSET_RESOLVER_MACROS_SVH
`define REGION_OFFSET_RESOLVER_MACROS_SVH

// Same-cycle implication, sampled on clk, muted during reset.
`define ROR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, muted during reset.
`define ROR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ror_pkg.sv =====
// ----------------------------------------------------------------------------
// Region offset resolver package
// Types, codes and sizes shared by the front, queue and back of the resolver.
// ----------------------------------------------------------------------------
package ror_pkg;

	localparam int MAX_REGIONS = 16;
	localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_RESOLVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_BAD_STATE = 2'd2,
		ST_BOUNDS    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_BASE_ADDRESS   = 2'd0,
		REG_BASE_PRESENT   = 2'd1,
		REG_CAPACITY_BYTES = 2'd2,
		REG_ACTIVE_REGIONS = 2'd3
	} cfg_reg_t;

	localparam logic [2:0] COND_ABSENT = 3'd0;
	localparam logic [2:0] COND_FAULT  = 3'd3;
	localparam logic [2:0] COND_TOKEN  = 3'd4;

	typedef struct packed {
		logic        command;
		logic [3:0]  slot;
		logic [31:0] region_key;
		logic [31:0] region_base_offset;
		logic [31:0] region_length;
		logic [2:0]  region_condition;
		logic [31:0] inner_offset;
		logic [31:0] span_length;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] resolved_address;
		logic        address_valid;
	} out_item_t;

	// Classified command as it waits between front and back.
	typedef struct packed {
		op_t              op;
		logic             slot_ok;
		logic [IDX_W-1:0] slot;
		logic [31:0]      key;
		logic [31:0]      arg_a;   // region offset on load, inner offset on resolve
		logic [31:0]      arg_b;   // region size on load, span length on resolve
		logic [2:0]       cond;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [63:0] base_address;
		logic        base_present;
		logic [31:0] capacity_bytes;
		logic [4:0]  active_regions;
	} cfg_t;

endpackage

// ===== src/region_offset_resolver.sv =====
// ----------------------------------------------------------------------------
// Region offset resolver
// Region table with first-match id lookup, span checks and base relocation.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------
//   in       | in_valid / in_stall | in_data   (load or resolve)
//   out      | out_valid/out_stall | out_data  (status, address)
//   cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One command per cycle sustained while the output is not stalled; the rate is
// set by the match stage, which compares the key against every active slot at once.
// A command passes through the queue and then the match, check and output registers.
// Reset clears the registers and the pipe; the region table is not cleared.
// out_stall freezes the whole back while a result is held; in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
`include "region_offset_resolver_macros.svh"

module region_offset_resolver (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ror_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ror_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  ror_pkg::cfg_reg_t  cfg_index,
	input  logic [63:0]        cfg_data
);
	import ror_pkg::*;

	cfg_t      cfg_q;
	q_entry_t  entry;
	q_entry_t  head;
	q_status_t q_stat;
	logic      push;
	logic      pop;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_stat.full;
	assign push      = in_valid && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASE_ADDRESS:   cfg_q.base_address   <= cfg_data;
				REG_BASE_PRESENT:   cfg_q.base_present   <= cfg_data[0];
				REG_CAPACITY_BYTES: cfg_q.capacity_bytes <= cfg_data[31:0];
				REG_ACTIVE_REGIONS: cfg_q.active_regions <= cfg_data[4:0];
			endcase
		end
	end

	ror_front u_front (
		.item  (in_data),
		.entry (entry)
	);

	ror_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	ror_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (!q_stat.empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	`ROR_ASSERT_SAME(a_addr_needs_ok, out_valid && out_data.address_valid, out_data.status == ST_OK, "address marked valid on a failed resolve")
	`ROR_ASSERT_SAME(a_fail_zero_addr, out_valid && out_data.status != ST_OK, out_data.resolved_address == '0, "failed resolve carries a nonzero address")
	`ROR_ASSERT_NEXT(a_push_lands, in_valid && !in_stall, !q_stat.empty, "accepted command missing from the queue")

endmodule

// ===== src/ror_front.sv =====
// ----------------------------------------------------------------------------
// Resolver front
// Decodes an incoming command and folds its fields into a queue entry.
// ----------------------------------------------------------------------------
module ror_front (
	input  ror_pkg::in_item_t item,
	output ror_pkg::q_entry_t entry
);
	import ror_pkg::*;

	always_comb begin
		entry.op      = op_t'(item.command);
		entry.slot_ok = int'(item.slot) < MAX_REGIONS;
		entry.slot    = IDX_W'(item.slot);
		entry.key     = item.region_key;
		entry.cond    = item.region_condition;
		if (item.command == OP_LOAD) begin
			entry.arg_a = item.region_base_offset;
			entry.arg_b = item.region_length;
		end else begin
			entry.arg_a = item.inner_offset;
			entry.arg_b = item.span_length;
		end
	end

endmodule

// ===== src/ror_queue.sv =====
// ----------------------------------------------------------------------------
// Resolver command queue
// Short FIFO that lets the front take commands while the back is stalled.
// ----------------------------------------------------------------------------
module ror_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ror_pkg::q_entry_t  push_data,
	input  logic               pop,
	output ror_pkg::q_entry_t  head,
	output ror_pkg::q_status_t stat
);
	import ror_pkg::*;

	q_entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = count_q == QCNT_W'(QDEPTH);
	assign stat.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/ror_back.sv =====
// ----------------------------------------------------------------------------
// Resolver back
// Holds the region table, runs the id match and the span checks in three
// stages and keeps the result in an output register.
// ----------------------------------------------------------------------------
module ror_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ror_pkg::cfg_t      cfg,
	input  logic               head_valid,
	input  ror_pkg::q_entry_t  head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output ror_pkg::out_item_t out_data
);
	import ror_pkg::*;

	logic [31:0] id_q   [MAX_REGIONS];
	logic [31:0] off_q  [MAX_REGIONS];
	logic [31:0] size_q [MAX_REGIONS];
	logic [2:0]  cond_q [MAX_REGIONS];

	logic                   en;
	logic [MAX_REGIONS-1:0] match;
	logic [MAX_REGIONS-1:0] first;
	logic [31:0]            hit_off;
	logic [31:0]            hit_size;
	logic [2:0]             hit_cond;

	logic        valid_s1;
	logic        is_load_s1;
	logic        found_s1;
	logic [2:0]  cond_s1;
	logic [31:0] size_s1;
	logic [31:0] off_s1;
	logic [31:0] local_s1;
	logic [31:0] span_s1;

	logic        bad_cond;
	logic        room_bad;
	logic [31:0] room_left;
	logic        decided;
	status_t     pre_status;
	logic [32:0] abs_off;

	logic        valid_s2;
	logic        decided_s2;
	status_t     status_s2;
	logic [32:0] abs_off_s2;
	logic [31:0] span_s2;

	logic [33:0] span_end;
	out_item_t   result;
	logic        out_valid_q;
	out_item_t   out_data_q;

	// The whole pipe moves whenever the output slot is free or being taken.
	assign en        = !out_valid_q || !out_stall;
	assign pop       = head_valid && en;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (pop && head.op == OP_LOAD && head.slot_ok) begin
			id_q[head.slot]   <= head.key;
			off_q[head.slot]  <= head.arg_a;
			size_q[head.slot] <= head.arg_b;
			cond_q[head.slot] <= head.cond;
		end
	end

	// Parallel id match; keep the lowest hit and AND-OR its entry out.
	always_comb begin
		for (int i = 0; i < MAX_REGIONS; i++) begin
			match[i] = (i < int'(cfg.active_regions)) && (id_q[i] == head.key);
		end
		first    = match & (~match + MAX_REGIONS'(1));
		hit_off  = '0;
		hit_size = '0;
		hit_cond = '0;
		for (int i = 0; i < MAX_REGIONS; i++) begin
			hit_off  = hit_off  | (off_q[i]  & {32{first[i]}});
			hit_size = hit_size | (size_q[i] & {32{first[i]}});
			hit_cond = hit_cond | (cond_q[i] & {3{first[i]}});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			is_load_s1 <= head.op == OP_LOAD;
			found_s1   <= |match;
			cond_s1    <= hit_cond;
			size_s1    <= hit_size;
			off_s1     <= hit_off;
			local_s1   <= head.arg_a;
			span_s1    <= head.arg_b;
		end
	end

	always_comb begin
		bad_cond  = cond_s1 == COND_ABSENT || cond_s1 == COND_FAULT
			|| cond_s1 == COND_TOKEN;
		room_left = size_s1 - local_s1;
		room_bad  = (local_s1 > size_s1) || (span_s1 > room_left);
		abs_off   = {1'b0, off_s1} + {1'b0, local_s1};
		decided    = 1'b1;
		pre_status = ST_OK;
		priority if (is_load_s1) begin
			pre_status = ST_OK;
		end else if (!found_s1) begin
			pre_status = ST_NOT_FOUND;
		end else if (bad_cond) begin
			pre_status = ST_BAD_STATE;
		end else if (room_bad) begin
			pre_status = ST_BOUNDS;
		end else begin
			decided = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			decided_s2 <= decided;
			status_s2  <= pre_status;
			abs_off_s2 <= abs_off;
			span_s2    <= span_s1;
		end
	end

	// Capacity check, null-base check and final address.
	always_comb begin
		span_end = {1'b0, abs_off_s2} + {2'b00, span_s2};
		result.status           = status_s2;
		result.resolved_address = '0;
		result.address_valid    = 1'b0;
		priority if (decided_s2) begin
			result.status = status_s2;
		end else if (span_end > {2'b00, cfg.capacity_bytes}) begin
			result.status = ST_BOUNDS;
		end else if (!cfg.base_present) begin
			result.status = (abs_off_s2 != '0 || span_s2 != '0) ? ST_BAD_STATE : ST_OK;
		end else begin
			result.status           = ST_OK;
			result.resolved_address = cfg.base_address + {31'b0, abs_off_s2};
			result.address_valid    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

endmodule

// ===== verif/region_offset_resolver_tb.sv =====
// ----------------------------------------------------------------------------
// Region offset resolver testbench
// Loads the region table and then sends resolve commands, with more loads mixed
// in, under several register settings and flow-control mixes. A scoreboard
// keeps its own copy of the table and the registers, predicts each answer, and
// compares every answer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module region_offset_resolver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ror_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PHASE_ITEMS  = 170;
	localparam int unsigned HOLD_CYCLES  = 400;

	// Condition codes the package leaves unnamed; the spare codes pass the state check.
	localparam logic [2:0] COND_EMPTY   = 3'd1;
	localparam logic [2:0] COND_PRESENT = 3'd2;
	localparam logic [2:0] COND_SPARE_A = 3'd5;
	localparam logic [2:0] COND_SPARE_B = 3'd6;
	localparam logic [2:0] COND_SPARE_C = 3'd7;

	class resolve_scoreboard;
		logic [31:0] id_of     [MAX_REGIONS];
		logic [31:0] offset_of [MAX_REGIONS];
		logic [31:0] size_of   [MAX_REGIONS];
		logic [2:0]  cond_of   [MAX_REGIONS];
		cfg_t        settings;
		out_item_t   awaited_answers [$];
		int unsigned mismatches;

		function new();
			settings   = '0;
			mismatches = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [63:0] value);
			case (idx)
				REG_BASE_ADDRESS:   settings.base_address   = value;
				REG_BASE_PRESENT:   settings.base_present   = value[0];
				REG_CAPACITY_BYTES: settings.capacity_bytes = value[31:0];
				REG_ACTIVE_REGIONS: settings.active_regions = value[4:0];
				default: ;
			endcase
		endfunction

		function out_item_t resolve_outcome(in_item_t cmd);
			out_item_t   ans;
			int unsigned searched;
			int          hit;
			logic [63:0] abs_off;
			logic [2:0]  cond;
			ans = '0;
			ans.status = ST_OK;
			if (cmd.command == OP_LOAD) begin
				id_of[cmd.slot]     = cmd.region_key;
				offset_of[cmd.slot] = cmd.region_base_offset;
				size_of[cmd.slot]   = cmd.region_length;
				cond_of[cmd.slot]   = cmd.region_condition;
				return ans;
			end
			searched = (settings.active_regions > MAX_REGIONS) ? MAX_REGIONS
				: settings.active_regions;
			hit = -1;
			for (int i = 0; i < searched; i++) begin
				if (hit < 0 && id_of[i] == cmd.region_key)
					hit = i;
			end
			if (hit < 0) begin
				ans.status = ST_NOT_FOUND;
				return ans;
			end
			cond = cond_of[hit];
			if (cond == COND_ABSENT || cond == COND_FAULT || cond == COND_TOKEN) begin
				ans.status = ST_BAD_STATE;
				return ans;
			end
			if (cmd.inner_offset > size_of[hit]
					|| cmd.span_length > size_of[hit] - cmd.inner_offset) begin
				ans.status = ST_BOUNDS;
				return ans;
			end
			abs_off = {32'd0, offset_of[hit]} + {32'd0, cmd.inner_offset};
			if (abs_off + {32'd0, cmd.span_length} > {32'd0, settings.capacity_bytes}) begin
				ans.status = ST_BOUNDS;
				return ans;
			end
			if (!settings.base_present) begin
				if (abs_off != 0 || cmd.span_length != 0)
					ans.status = ST_BAD_STATE;
				return ans;
			end
			ans.resolved_address = settings.base_address + abs_off;
			ans.address_valid    = 1'b1;
			return ans;
		endfunction

		function void note_command(in_item_t cmd);
			awaited_answers.push_back(resolve_outcome(cmd));
		endfunction

		function void report(string what, out_item_t exp, out_item_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t %s: exp st %0d addr %h v %b, got st %0d addr %h v %b",
					$time, what, exp.status, exp.resolved_address, exp.address_valid,
					got.status, got.resolved_address, got.address_valid);
		endfunction

		function void check_answer(out_item_t got);
			out_item_t exp;
			if (awaited_answers.size() == 0) begin
				report("unexpected answer", '0, got);
				return;
			end
			exp = awaited_answers.pop_front();
			if (got.status !== exp.status || got.resolved_address !== exp.resolved_address
					|| got.address_valid !== exp.address_valid)
				report("answer mismatch", exp, got);
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_reg_t    cfg_index = REG_BASE_ADDRESS;
	logic [63:0] cfg_data  = '0;

	resolve_scoreboard sb;
	int unsigned       send_idle_pct = 0;
	int unsigned       stall_pct     = 0;
	int unsigned       hold_request  = 0;
	int unsigned       cycle_count   = 0;

	region_offset_resolver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_answer(out_data);
	end

	// Receiver: random stall, or a long hold-off when one is requested.
	initial begin : sink
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic in_item_t load_cmd(logic [3:0] slot, logic [31:0] key,
			logic [31:0] offset, logic [31:0] extent, logic [2:0] cond);
		in_item_t item;
		item.command            = OP_LOAD;
		item.slot               = slot;
		item.region_key         = key;
		item.region_base_offset = offset;
		item.region_length      = extent;
		item.region_condition   = cond;
		item.inner_offset       = $urandom;
		item.span_length        = $urandom;
		return item;
	endfunction

	function automatic in_item_t resolve_cmd(logic [31:0] key, logic [31:0] loc_off,
			logic [31:0] span);
		in_item_t item;
		item.command            = OP_RESOLVE;
		item.slot               = 4'($urandom_range(15));
		item.region_key         = key;
		item.region_base_offset = $urandom;
		item.region_length      = $urandom;
		item.region_condition   = 3'($urandom_range(7));
		item.inner_offset       = loc_off;
		item.span_length        = span;
		return item;
	endfunction

	// Values clustered on the edges of a limit.
	function automatic logic [31:0] near_edge(logic [31:0] limit);
		case ($urandom_range(5))
			0: return 32'd0;
			1: return limit;
			2: return limit + 32'd1;
			3: return $urandom;
			default: return $urandom_range(limit);
		endcase
	endfunction

	function automatic in_item_t random_load(logic [3:0] slot);
		logic [31:0] key;
		logic [31:0] offset;
		logic [31:0] extent;
		logic [2:0]  cond;
		case ($urandom_range(3))
			0, 1: key = 32'h100 + $urandom_range(15);
			2: key = $urandom;
			default: key = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
		endcase
		offset = $urandom_range(1) ? 32'($urandom_range(32'hFFFF)) : 32'($urandom);
		case ($urandom_range(3))
			0: extent = $urandom_range(32'h1000);
			1: extent = $urandom;
			2: extent = 32'hFFFF_FFFF;
			default: extent = $urandom_range(16);
		endcase
		if ($urandom_range(99) < 60)
			cond = $urandom_range(1) ? COND_PRESENT : COND_EMPTY;
		else
			cond = 3'($urandom_range(7));
		return load_cmd(slot, key, offset, extent, cond);
	endfunction

	function automatic in_item_t random_resolve();
		int unsigned searched;
		int unsigned pick;
		logic [31:0] key;
		logic [31:0] room;
		logic [31:0] loc_off;
		searched = (sb.settings.active_regions > MAX_REGIONS) ? MAX_REGIONS
			: sb.settings.active_regions;
		if (searched != 0 && $urandom_range(99) < 80) begin
			pick = $urandom_range(searched - 1);
			key  = sb.id_of[pick];
			room = sb.size_of[pick];
		end else begin
			key  = $urandom_range(1) ? 32'($urandom) : 32'h100 + $urandom_range(15);
			room = $urandom;
		end
		loc_off = near_edge(room);
		return resolve_cmd(key, loc_off, near_edge(room - loc_off));
	endfunction

	// Leave in_valid high on return so back-to-back transactions stay seamless.
	task automatic offer(input in_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall);
		sb.note_command(item);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.awaited_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [63:0] base, input logic present,
			input logic [31:0] cap, input logic [4:0] active);
		logic [63:0] value [4];
		cfg_reg_t    reg_idx;
		value[REG_BASE_ADDRESS]   = base;
		value[REG_BASE_PRESENT]   = {63'd0, present};
		value[REG_CAPACITY_BYTES] = {32'd0, cap};
		value[REG_ACTIVE_REGIONS] = {59'd0, active};
		reg_idx = reg_idx.first();
		do begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_idx;
			cfg_data  <= value[reg_idx];
			do @(posedge clk); while (!cfg_ready);
			sb.set_register(reg_idx, value[reg_idx]);
			reg_idx = reg_idx.next();
		end while (reg_idx != reg_idx.first());
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No slot searched yet: nothing can match.
		offer(resolve_cmd(32'h105, 32'd0, 32'd0));

		offer(load_cmd(4'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, COND_PRESENT));
		offer(load_cmd(4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, COND_EMPTY));
		offer(load_cmd(4'd2, 32'h100, 32'h40, 32'h40, COND_ABSENT));
		offer(load_cmd(4'd3, 32'h101, 32'h40, 32'h40, COND_FAULT));
		offer(load_cmd(4'd4, 32'h102, 32'h40, 32'h40, COND_TOKEN));
		offer(load_cmd(4'd5, 32'h103, 32'h1000, 32'h100, COND_SPARE_A));
		offer(load_cmd(4'd6, 32'h104, 32'h8000_0000, 32'h7FFF_FFFF, COND_SPARE_B));
		offer(load_cmd(4'd7, 32'h105, 32'h10, 32'h20, COND_SPARE_C));
		// Duplicate id behind slot 7: first match must win.
		offer(load_cmd(4'd8, 32'h105, 32'h0, 32'h0, COND_ABSENT));
		settle();

		// Base sits 0x1010 below the top so one span wraps to address zero.
		configure(64'hFFFF_FFFF_FFFF_EFF0, 1'b1, 32'hFFFF_FFFF, 5'd9);
		offer(resolve_cmd(32'h105, 32'h0, 32'h20));
		offer(resolve_cmd(32'h100, 32'h0, 32'h0));
		offer(resolve_cmd(32'h101, 32'h0, 32'h0));
		offer(resolve_cmd(32'h102, 32'h0, 32'h0));
		offer(resolve_cmd(32'h103, 32'h101, 32'h0));
		offer(resolve_cmd(32'h103, 32'h80, 32'h81));
		offer(resolve_cmd(32'h103, 32'h10, 32'hF0));
		offer(resolve_cmd(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
		offer(resolve_cmd(32'h104, 32'h7FFF_FFFF, 32'h0));
		offer(resolve_cmd(32'hDEAD_BEEF, 32'h0, 32'h0));
		settle();

		// Null base, capacity one byte short of the end of slot 5's span.
		configure(64'd0, 1'b0, 32'h10FF, 5'd9);
		offer(resolve_cmd(32'h0, 32'h0, 32'h0));
		offer(resolve_cmd(32'h103, 32'h0, 32'hFF));
		offer(resolve_cmd(32'h103, 32'h0, 32'h100));

		// Fill the rest of the table before any wider search.
		for (int s = 9; s < MAX_REGIONS; s++)
			offer(random_load(4'(s)));
		settle();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 64; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 64; end
				default: begin send_idle_pct = 16; stall_pct = 16; end
			endcase
			case (phase)
				0: configure({$urandom, $urandom}, 1'b1, 32'hFFFF_FFFF, 5'd16);
				1: configure(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, $urandom | 32'h8000_0000, 5'd31);
				2: configure(64'd0, 1'b0, 32'hFFFF_FFFF, 5'd1);
				3: configure({$urandom, $urandom}, 1'b1, 32'd0, 5'd16);
				4: configure({$urandom, $urandom}, 1'b0, $urandom | 32'h8000_0000,
					5'($urandom_range(31)));
				5: configure({$urandom, $urandom}, 1'b1, 32'hFFFF_FFFF,
					5'($urandom_range(1, 16)));
				6: configure(64'd0, 1'b1, 32'hFFFF_FFFF, 5'd16);
				default: configure({$urandom, $urandom}, 1'b1, $urandom, 5'd0);
			endcase
			// Block the output while commands keep coming so the input backs up.
			if (phase == 1)
				hold_request = HOLD_CYCLES;
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(99) < 20)
					offer(random_load(4'($urandom_range(15))));
				else
					offer(random_resolve());
			end
			settle();
		end

		if (sb.mismatches == 0 && sb.awaited_answers.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== region_offset_resolver.f =====
+incdir+src
src/ror_pkg.sv
src/ror_front.sv
src/ror_queue.sv
src/ror_back.sv
src/region_offset_resolver.sv
verif/region_offset_resolver_tb.sv
